>>> src/wsed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsed_pkg;
	localparam int Window = 50;
	localparam int SoftSlots = 16;
	localparam int CntW = $clog2(Window + 1);
	localparam int SoftW = $clog2(SoftSlots + 1);

	typedef enum logic [1:0] {
		CLS_INIT     = 2'd0,
		CLS_STABLE   = 2'd1,
		CLS_SOFT     = 2'd2,
		CLS_UNSTABLE = 2'd3
	} load_class_t;

	typedef enum logic [1:0] {
		REG_STABLE = 2'd0,
		REG_SOFT   = 2'd1,
		REG_ACTION = 2'd2
	} reg_index_t;

	// Control from the sequencer to every window cell.
	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctrl_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic        [47:0] stamp;
	} cell_data_t;
endpackage
`default_nettype wire

>>> src/wsed_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One window slot. A shift pushes the new sample in at the head of the chain;
// a rotate passes the oldest entry round from the tail so the window is walked.
module wsed_cell
	import wsed_pkg::*;
(
	input  wire        clk,
	input  cell_ctrl_t ctrl,
	input  cell_data_t din,
	output cell_data_t dout
);
	cell_data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift || ctrl.rotate) begin
			data_q <= din;
		end
	end

	assign dout = data_q;
endmodule
`default_nettype wire

>>> src/window_stability_event_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Stability classifier over the last 50 weight samples. Samples are held in a
// chain of 50 cells. Once the window is full, each sample walks the window once
// through the chain, one entry per cycle, to find the largest neighbour gap and
// the sum. It then forms the mean (a reciprocal multiply built from two partial
// products, then the scaling), makes the class and event decisions and stores
// the sample. While the window fills, a sample skips the walk and the decisions
// and goes straight to the store step, which offers the result. The result
// waits in an output register and the next sample is taken only once that
// register is free, so a new sample is never taken while the previous one is
// still being worked on or its result is still waiting.
module window_stability_event_detector_unit
	import wsed_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [1:0]          cfg_index,
	input  wire [30:0]         cfg_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [47:0]         sample_time,
	input  wire signed [31:0]  sample_value,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               class_changed,
	output logic [1:0]         load_class,
	output logic [47:0]        change_time,
	output logic               deposit_event,
	output logic signed [32:0] deposit_weight,
	output logic signed [32:0] visitor_weight,
	output logic               emptied_event,
	output logic [15:0]        deposit_count
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_WALK, ST_DIV, ST_MUL, ST_MEAN, ST_DECIDE, ST_STORE
	} state_t;

	localparam int RecipShift = 44;
	localparam logic [39:0] Recip = 40'((64'd1 << RecipShift) / Window + 1);

	state_t                    state_q;
	logic [30:0]               stable_lim_q, soft_lim_q, action_lim_q;
	logic [CntW-1:0]           fill_q, walk_q;
	logic [1:0]                last_class_q;
	logic signed [31:0]        baseline_q, soft_peak_q;
	logic [SoftW-1:0]          soft_entries_q;
	logic [15:0]               deposits_q;
	logic [47:0]               t_q;
	logic signed [31:0]        v_q;
	logic signed [37:0]        sum_q;
	logic [32:0]               gap_q;
	logic signed [31:0]        prev_q;
	logic [47:0]               oldest_t_q;
	logic signed [31:0]        avg_q;
	logic [77:0]               prod_q;

	cell_ctrl_t                ctrl;
	cell_data_t                chain [Window+1];

	// Head of the chain: new sample on a shift, tail entry on a rotate.
	assign chain[0] = ctrl.shift ? cell_data_t'{value: v_q, stamp: t_q} : chain[Window];

	for (genvar g = 0; g < Window; g++) begin : g_cell
		wsed_cell u_cell (.clk(clk), .ctrl(ctrl), .din(chain[g]), .dout(chain[g+1]));
	end

	// Once the window is full and outside the walk, the tail of the chain (chain[Window]) holds the oldest entry.
	assign ctrl.rotate = (state_q == ST_WALK);
	assign ctrl.shift  = (state_q == ST_STORE);
	assign in_stall    = (state_q != ST_IDLE) || out_valid;

	logic signed [32:0] diff_w;
	logic [32:0]        absd;
	assign diff_w = 33'(prev_q) - 33'(chain[Window].value);
	assign absd   = diff_w[32] ? 33'(-diff_w) : diff_w;

	// Mean truncated toward zero via reciprocal multiply of the magnitude.
	// The product is built from two partial products on consecutive cycles.
	logic [37:0] mag;
	logic [37:0] quo;
	assign mag  = sum_q[37] ? 38'(-sum_q) : 38'(sum_q);
	assign quo  = 38'(prod_q >> RecipShift);

	logic [1:0]          cls;
	logic signed [33:0]  diff_b;
	logic signed [33:0]  action_s;
	logic signed [32:0]  peak;
	assign cls = (gap_q < {2'b0, stable_lim_q}) ? CLS_STABLE :
		(gap_q < {2'b0, soft_lim_q}) ? CLS_SOFT : CLS_UNSTABLE;
	assign diff_b   = 34'(avg_q) - 34'(baseline_q);
	assign action_s = $signed({3'b0, action_lim_q});
	assign peak = (soft_entries_q != '0 && !soft_peak_q[31]) ? 33'(soft_peak_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			stable_lim_q   <= 31'd100;
			soft_lim_q     <= 31'd1000;
			action_lim_q   <= 31'd500;
			fill_q         <= '0;
			walk_q         <= '0;
			last_class_q   <= CLS_INIT;
			baseline_q     <= '0;
			soft_peak_q    <= '0;
			soft_entries_q <= '0;
			deposits_q     <= '0;
			out_valid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STABLE: stable_lim_q <= cfg_data;
					REG_SOFT:   soft_lim_q   <= cfg_data;
					REG_ACTION: action_lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						t_q <= sample_time;
						v_q <= sample_value;
						class_changed  <= 1'b0;
						change_time    <= '0;
						deposit_event  <= 1'b0;
						deposit_weight <= '0;
						visitor_weight <= '0;
						emptied_event  <= 1'b0;
						sum_q  <= '0;
						gap_q  <= '0;
						walk_q <= '0;
						oldest_t_q <= chain[Window].stamp;
						prev_q <= chain[Window].value;
						state_q <= (fill_q == CntW'(Window)) ? ST_WALK : ST_STORE;
					end
				end
				ST_WALK: begin
					sum_q  <= sum_q + 38'(chain[Window].value);
					if (walk_q != '0 && gap_q < absd) gap_q <= absd;
					prev_q <= chain[Window].value;
					walk_q <= walk_q + 1'b1;
					if (walk_q == CntW'(Window - 1)) state_q <= ST_DIV;
				end
				ST_DIV: begin
					prod_q  <= 78'(mag) * 78'(Recip[19:0]);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= prod_q + ((78'(mag) * 78'(Recip[39:20])) << 20);
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					avg_q   <= sum_q[37] ? -32'(quo) : 32'(quo);
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (cls != last_class_q) begin
						class_changed <= 1'b1;
						change_time   <= (last_class_q < cls) ? t_q : oldest_t_q;
						last_class_q  <= cls;
						if (cls == CLS_STABLE && last_class_q != CLS_INIT) begin
							if (diff_b > action_s) begin
								deposit_event  <= 1'b1;
								deposit_weight <= 33'(diff_b);
								visitor_weight <= peak - 33'(avg_q);
								deposits_q     <= deposits_q + 16'd1;
							end else if (diff_b < -action_s) begin
								emptied_event <= 1'b1;
								deposits_q    <= '0;
							end
							soft_entries_q <= '0;
							soft_peak_q    <= '0;
						end
						if (cls == CLS_SOFT) begin
							if (soft_entries_q + 1'b1 >= SoftW'(SoftSlots)) begin
								soft_entries_q <= '0;
								soft_peak_q    <= '0;
							end else begin
								soft_entries_q <= soft_entries_q + 1'b1;
								if (soft_entries_q == '0 || soft_peak_q < avg_q)
									soft_peak_q <= avg_q;
							end
						end
					end
					if (cls == CLS_STABLE) baseline_q <= avg_q;
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					// The oldest entry falls off the tail when the window is full.
					if (fill_q != CntW'(Window)) fill_q <= fill_q + 1'b1;
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign load_class    = last_class_q;
	assign deposit_count = deposits_q;
endmodule
`default_nettype wire

>>> src/wsed_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module wsed_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire        class_changed,
	input wire [47:0] change_time,
	input wire        deposit_event,
	input wire        emptied_event,
	input wire [15:0] deposit_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !out_valid)
		else $error("sample taken while a result is waiting");
	a_event_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (deposit_event || emptied_event) |-> class_changed)
		else $error("event without class change");
	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !class_changed |-> change_time == 48'd0)
		else $error("change time without change");
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && emptied_event |-> deposit_count == 16'd0)
		else $error("count not cleared on emptied");
endmodule

bind window_stability_event_detector_unit wsed_checker u_wsed_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .class_changed(class_changed),
	.change_time(change_time), .deposit_event(deposit_event),
	.emptied_event(emptied_event), .deposit_count(deposit_count)
);
`default_nettype wire
